FILE: design/bfha_pkg.sv
// ----------------------------------------------------------------------------
// bfha_pkg
// Shared types, sizes and codes of the best-fit heap allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;

   localparam int ARENA_BITS = 20;
   localparam int FREE_SLOTS = 16;
   localparam int USED_SLOTS = 16;

   localparam int FIDX_W  = $clog2(FREE_SLOTS);
   localparam int FCNT_W  = $clog2(FREE_SLOTS + 1);
   localparam int UIDX_W  = $clog2(USED_SLOTS);
   localparam int UCNT_W  = $clog2(USED_SLOTS + 1);
   localparam int VAL_W   = ARENA_BITS + 1;
   localparam int CHUNK_W = 21;
   localparam int HDR_W   = 7;
   localparam int LIMIT_W = 21;
   localparam int SIZE_W  = 20;
   localparam int ADDR_W  = 20;
   localparam int SUM_W   = ((VAL_W > CHUNK_W) ? VAL_W : CHUNK_W) + 3;
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   localparam logic [CHUNK_W-1:0] CHUNK_RESET  = CHUNK_W'(8192);
   localparam logic [HDR_W-1:0]   HDR_RESET    = HDR_W'(16);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(1048576);

   typedef enum logic [1:0] {
      REG_CHUNK_SIZE  = 2'd0,
      REG_HEADER_SIZE = 2'd1,
      REG_ARENA_LIMIT = 2'd2
   } reg_index_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TOO_LARGE = 3'd1,
      ST_OOM       = 3'd2,
      ST_NULL      = 3'd3,
      ST_FULL      = 3'd4,
      ST_UNKNOWN   = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_FIT,
      S_GROW,
      S_MERGE,
      S_INS_POS,
      S_INS_SHIFT,
      S_PLACE,
      S_REM_SHIFT,
      S_USED_ADD,
      S_FREE_FIND,
      S_FREE_SCAN,
      S_FREE_JOIN,
      S_USED_READ,
      S_USED_MOVE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              command;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] user_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] granted_address;
      logic [2:0]        status;
   } rsp_type;

   typedef struct packed {
      logic [CHUNK_W-1:0] chunk_size;
      logic [HDR_W-1:0]   header_size;
      logic [LIMIT_W-1:0] arena_limit;
   } cfg_type;

endpackage

FILE: design/bfha_csr.sv
// ----------------------------------------------------------------------------
// bfha_csr
// APB-style register file holding chunk size, header size and arena limit.
// ----------------------------------------------------------------------------
module bfha_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bfha_pkg::PADDR_W-1:0] paddr,
   input  logic [bfha_pkg::PDATA_W-1:0] pwdata,
   output logic [bfha_pkg::PDATA_W-1:0] prdata,
   output logic                         pready,
   output bfha_pkg::cfg_type            cfg
);
   import bfha_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[3:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_CHUNK_SIZE:  cfg_in.chunk_size  = pwdata[CHUNK_W-1:0];
            REG_HEADER_SIZE: cfg_in.header_size = pwdata[HDR_W-1:0];
            REG_ARENA_LIMIT: cfg_in.arena_limit = pwdata[LIMIT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_CHUNK_SIZE:  prdata = PDATA_W'(cfg_ff.chunk_size);
         REG_HEADER_SIZE: prdata = PDATA_W'(cfg_ff.header_size);
         REG_ARENA_LIMIT: prdata = PDATA_W'(cfg_ff.arena_limit);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chunk_size  <= CHUNK_RESET;
         cfg_ff.header_size <= HDR_RESET;
         cfg_ff.arena_limit <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/bfha_engine.sv
// ----------------------------------------------------------------------------
// bfha_engine
// Sequencer over the free and used tables: one entry read and one written
// per cycle, with one shared set of adders and comparators.
// ----------------------------------------------------------------------------
module bfha_engine (
   input  logic              clock,
   input  logic              reset,
   input  bfha_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  bfha_pkg::req_type req,
   input  logic              out_busy,
   output logic              done,
   output bfha_pkg::rsp_type rsp
);
   import bfha_pkg::*;

   state_type state_ff, state_in;

   logic [VAL_W-1:0] fs_ff [FREE_SLOTS];
   logic [VAL_W-1:0] fl_ff [FREE_SLOTS];
   logic [VAL_W-1:0] us_ff [USED_SLOTS];
   logic [VAL_W-1:0] ul_ff [USED_SLOTS];

   logic [FCNT_W-1:0] free_cnt_ff, free_cnt_in, idx_ff, idx_in;
   logic [UCNT_W-1:0] used_cnt_ff, used_cnt_in, uidx_ff, uidx_in;
   logic [FIDX_W-1:0] best_ff, best_in, left_ff, left_in, right_ff, right_in;
   logic [FIDX_W-1:0] ins_pos_ff, ins_pos_in;
   logic              best_found_ff, best_found_in, lf_ff, lf_in, rf_ff, rf_in;
   logic [VAL_W-1:0]  best_len_ff, best_len_in, rlen_ff, rlen_in;
   logic [VAL_W-1:0]  blk_start_ff, blk_start_in, blk_len_ff, blk_len_in;
   logic [VAL_W-1:0]  ins_start_ff, ins_start_in, ins_len_ff, ins_len_in;
   logic [VAL_W-1:0]  break_ff, break_in;
   logic              cmd_ff, cmd_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] grant_ff, grant_in;
   status_type        status_ff, status_in;

   // table write port
   logic              fw_s_en, fw_l_en, uw_en;
   logic [FIDX_W-1:0] fw_idx;
   logic [VAL_W-1:0]  fw_start, fw_len;
   logic [UIDX_W-1:0] uw_idx;
   logic [VAL_W-1:0]  uw_start, uw_len;

   // table read port
   logic [FIDX_W-1:0] frd_idx;
   logic [UIDX_W-1:0] urd_idx;
   logic [VAL_W-1:0]  f_start, f_len, u_start, u_len;

   logic [SUM_W-1:0] hdr_s, size_s, chunk_s, break_s, limit_s, cap_s;
   logic [SUM_W-1:0] f_start_s, f_len_s, f_end_s, blk_start_s, blk_end_s;
   logic scan_end, exact, larger, too_large, oom, merge_hit, ins_here, split;
   logic rem_end, used_full, free_full, u_end, u_hit, left_hit, right_hit;

   always_comb begin
      case (state_ff)
         S_INS_SHIFT: frd_idx = FIDX_W'(idx_ff - 1'b1);
         S_REM_SHIFT: frd_idx = FIDX_W'(idx_ff + 1'b1);
         S_PLACE:     frd_idx = best_ff;
         S_FREE_JOIN: frd_idx = left_ff;
         default:     frd_idx = idx_ff[FIDX_W-1:0];
      endcase
   end

   assign urd_idx = (state_ff == S_USED_READ) ? UIDX_W'(used_cnt_ff - 1'b1)
                                              : uidx_ff[UIDX_W-1:0];
   assign f_start = fs_ff[frd_idx];
   assign f_len   = fl_ff[frd_idx];
   assign u_start = us_ff[urd_idx];
   assign u_len   = ul_ff[urd_idx];

   assign hdr_s       = SUM_W'(cfg.header_size);
   assign size_s      = SUM_W'(size_ff);
   assign chunk_s     = SUM_W'(cfg.chunk_size);
   assign break_s     = SUM_W'(break_ff);
   assign cap_s       = SUM_W'(1) << ARENA_BITS;
   assign limit_s     = (SUM_W'(cfg.arena_limit) > cap_s) ? cap_s : SUM_W'(cfg.arena_limit);
   assign f_start_s   = SUM_W'(f_start);
   assign f_len_s     = SUM_W'(f_len);
   assign f_end_s     = f_start_s + hdr_s + f_len_s;
   assign blk_start_s = SUM_W'(blk_start_ff);
   assign blk_end_s   = blk_start_s + hdr_s + SUM_W'(blk_len_ff);

   assign scan_end  = (idx_ff == free_cnt_ff);
   assign exact     = (f_len_s == size_s);
   assign larger    = (f_len_s > size_s) && (!best_found_ff || (f_len < best_len_ff));
   assign too_large = (size_s + hdr_s) > chunk_s;
   assign oom       = (break_s + chunk_s) > limit_s;
   assign merge_hit = (f_end_s == break_s);
   assign ins_here  = scan_end || !(f_start < ins_start_ff);
   assign split     = f_len_s >= (size_s + hdr_s + SUM_W'(1));
   assign rem_end   = ((FCNT_W+1)'(idx_ff) + 1'b1) >= (FCNT_W+1)'(free_cnt_ff);
   assign used_full = (used_cnt_ff == UCNT_W'(USED_SLOTS));
   assign free_full = (free_cnt_ff == FCNT_W'(FREE_SLOTS));
   assign u_end     = (uidx_ff == used_cnt_ff);
   assign u_hit     = (SUM_W'(u_start) + hdr_s) == SUM_W'(addr_ff);
   assign left_hit  = (f_end_s == blk_start_s);
   assign right_hit = (f_start_s == blk_end_s);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:      if (req_valid) state_in = S_CHECK;
         S_CHECK: begin
            if (cmd_ff == CMD_ALLOC) begin
               if (too_large || size_ff == '0 || used_full) state_in = S_DONE;
               else state_in = S_FIT;
            end else begin
               state_in = (addr_ff == '0) ? S_DONE : S_FREE_FIND;
            end
         end
         S_FIT: begin
            if (scan_end) state_in = best_found_ff ? S_PLACE : S_GROW;
            else if (exact) state_in = S_PLACE;
         end
         S_GROW:      state_in = oom ? S_DONE : S_MERGE;
         S_MERGE: begin
            if (scan_end) state_in = free_full ? S_DONE : S_INS_POS;
            else if (merge_hit) state_in = S_FIT;
         end
         S_INS_POS:   if (ins_here) state_in = S_INS_SHIFT;
         S_INS_SHIFT: begin
            if (idx_ff == FCNT_W'(ins_pos_ff))
               state_in = (cmd_ff == CMD_ALLOC) ? S_FIT : S_USED_READ;
         end
         S_PLACE:     state_in = split ? S_USED_ADD : S_REM_SHIFT;
         S_REM_SHIFT: begin
            if (rem_end) state_in = (cmd_ff == CMD_ALLOC) ? S_USED_ADD : S_USED_READ;
         end
         S_USED_ADD:  state_in = S_DONE;
         S_FREE_FIND: begin
            if (u_end) state_in = S_DONE;
            else if (u_hit) state_in = S_FREE_SCAN;
         end
         S_FREE_SCAN: if (scan_end) state_in = S_FREE_JOIN;
         S_FREE_JOIN: begin
            if (lf_ff && rf_ff) state_in = S_REM_SHIFT;
            else if (lf_ff || rf_ff) state_in = S_USED_READ;
            else state_in = free_full ? S_DONE : S_INS_POS;
         end
         S_USED_READ: state_in = S_USED_MOVE;
         S_USED_MOVE: state_in = S_DONE;
         S_DONE:      if (!out_busy) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      free_cnt_in   = free_cnt_ff;
      used_cnt_in   = used_cnt_ff;
      idx_in        = idx_ff;
      uidx_in       = uidx_ff;
      best_in       = best_ff;
      best_found_in = best_found_ff;
      best_len_in   = best_len_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      lf_in         = lf_ff;
      rf_in         = rf_ff;
      rlen_in       = rlen_ff;
      ins_pos_in    = ins_pos_ff;
      ins_start_in  = ins_start_ff;
      ins_len_in    = ins_len_ff;
      blk_start_in  = blk_start_ff;
      blk_len_in    = blk_len_ff;
      break_in      = break_ff;
      cmd_in        = cmd_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      grant_in      = grant_ff;
      status_in     = status_ff;
      fw_s_en       = 1'b0;
      fw_l_en       = 1'b0;
      fw_idx        = frd_idx;
      fw_start      = f_start;
      fw_len        = f_len;
      uw_en         = 1'b0;
      uw_idx        = used_cnt_ff[UIDX_W-1:0];
      uw_start      = blk_start_ff;
      uw_len        = blk_len_ff;
      req_ready     = (state_ff == S_IDLE);
      done          = (state_ff == S_DONE) && !out_busy;
      case (state_ff)
         S_IDLE: begin
            cmd_in    = req.command;
            size_in   = req.request_size;
            addr_in   = req.user_address;
            grant_in  = '0;
            status_in = ST_OK;
            idx_in    = '0;
            uidx_in   = '0;
            best_found_in = 1'b0;
            lf_in     = 1'b0;
            rf_in     = 1'b0;
         end
         S_CHECK: begin
            if (cmd_ff == CMD_ALLOC) begin
               if (too_large) status_in = ST_TOO_LARGE;
               else if (size_ff == '0) status_in = ST_NULL;
               else if (used_full) status_in = ST_FULL;
            end else if (addr_ff == '0) begin
               status_in = ST_NULL;
            end
         end
         S_FIT: begin
            if (!scan_end) begin
               if (exact) begin
                  best_in = idx_ff[FIDX_W-1:0];
                  best_found_in = 1'b1;
               end else if (larger) begin
                  best_in = idx_ff[FIDX_W-1:0];
                  best_len_in = f_len;
                  best_found_in = 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         S_GROW: begin
            idx_in = '0;
            if (oom) status_in = ST_OOM;
         end
         S_MERGE: begin
            if (scan_end) begin
               if (free_full) begin
                  status_in = ST_FULL;
               end else begin
                  ins_start_in = break_ff;
                  ins_len_in   = VAL_W'(chunk_s - hdr_s);
                  break_in     = VAL_W'(break_s + chunk_s);
                  idx_in       = '0;
               end
            end else if (merge_hit) begin
               fw_l_en  = 1'b1;
               fw_len   = VAL_W'(f_len_s + chunk_s);
               break_in = VAL_W'(break_s + chunk_s);
               idx_in   = '0;
               best_found_in = 1'b0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_INS_POS: begin
            if (ins_here) begin
               ins_pos_in = idx_ff[FIDX_W-1:0];
               idx_in     = free_cnt_ff;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_INS_SHIFT: begin
            fw_s_en = 1'b1;
            fw_l_en = 1'b1;
            fw_idx  = idx_ff[FIDX_W-1:0];
            if (idx_ff == FCNT_W'(ins_pos_ff)) begin
               fw_start      = ins_start_ff;
               fw_len        = ins_len_ff;
               free_cnt_in   = free_cnt_ff + 1'b1;
               idx_in        = '0;
               best_found_in = 1'b0;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         S_PLACE: begin
            if (split) begin
               blk_start_in = VAL_W'(f_start_s + f_len_s - size_s);
               blk_len_in   = VAL_W'(size_s);
               fw_l_en      = 1'b1;
               fw_len       = VAL_W'(f_len_s - hdr_s - size_s);
            end else begin
               blk_start_in = f_start;
               blk_len_in   = f_len;
               idx_in       = FCNT_W'(best_ff);
            end
         end
         S_REM_SHIFT: begin
            if (rem_end) begin
               free_cnt_in = free_cnt_ff - 1'b1;
            end else begin
               fw_s_en = 1'b1;
               fw_l_en = 1'b1;
               fw_idx  = idx_ff[FIDX_W-1:0];
               idx_in  = idx_ff + 1'b1;
            end
         end
         S_USED_ADD: begin
            uw_en       = 1'b1;
            used_cnt_in = used_cnt_ff + 1'b1;
            grant_in    = ADDR_W'(blk_start_s + hdr_s);
            status_in   = ST_OK;
         end
         S_FREE_FIND: begin
            if (u_end) begin
               status_in = ST_UNKNOWN;
            end else if (u_hit) begin
               blk_start_in = u_start;
               blk_len_in   = u_len;
               idx_in       = '0;
            end else begin
               uidx_in = uidx_ff + 1'b1;
            end
         end
         S_FREE_SCAN: begin
            if (!scan_end) begin
               if (left_hit) begin
                  left_in = idx_ff[FIDX_W-1:0];
                  lf_in   = 1'b1;
               end
               if (right_hit) begin
                  right_in = idx_ff[FIDX_W-1:0];
                  rf_in    = 1'b1;
                  rlen_in  = f_len;
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FREE_JOIN: begin
            if (lf_ff && rf_ff) begin
               fw_l_en = 1'b1;
               fw_len  = VAL_W'(f_len_s + hdr_s + SUM_W'(blk_len_ff) + hdr_s
                                + SUM_W'(rlen_ff));
               idx_in  = FCNT_W'(right_ff);
            end else if (lf_ff) begin
               fw_l_en = 1'b1;
               fw_len  = VAL_W'(f_len_s + hdr_s + SUM_W'(blk_len_ff));
            end else if (rf_ff) begin
               fw_s_en  = 1'b1;
               fw_l_en  = 1'b1;
               fw_idx   = right_ff;
               fw_start = blk_start_ff;
               fw_len   = VAL_W'(SUM_W'(rlen_ff) + hdr_s + SUM_W'(blk_len_ff));
            end else if (free_full) begin
               status_in = ST_FULL;
            end else begin
               ins_start_in = blk_start_ff;
               ins_len_in   = blk_len_ff;
               idx_in       = '0;
            end
         end
         S_USED_READ: begin
            used_cnt_in  = used_cnt_ff - 1'b1;
            blk_start_in = u_start;
            blk_len_in   = u_len;
         end
         S_USED_MOVE: begin
            uw_en     = 1'b1;
            uw_idx    = uidx_ff[UIDX_W-1:0];
            status_in = ST_OK;
            grant_in  = '0;
         end
         default: begin
            status_in = status_ff;
         end
      endcase
   end

   assign rsp.granted_address = grant_ff;
   assign rsp.status          = status_ff;

   always_ff @(posedge clock) begin
      if (fw_s_en) fs_ff[fw_idx] <= fw_start;
      if (fw_l_en) fl_ff[fw_idx] <= fw_len;
      if (uw_en) begin
         us_ff[uw_idx] <= uw_start;
         ul_ff[uw_idx] <= uw_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         free_cnt_ff <= '0;
         used_cnt_ff <= '0;
         break_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         free_cnt_ff <= free_cnt_in;
         used_cnt_ff <= used_cnt_in;
         break_ff    <= break_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      uidx_ff       <= uidx_in;
      best_ff       <= best_in;
      best_found_ff <= best_found_in;
      best_len_ff   <= best_len_in;
      left_ff       <= left_in;
      right_ff      <= right_in;
      lf_ff         <= lf_in;
      rf_ff         <= rf_in;
      rlen_ff       <= rlen_in;
      ins_pos_ff    <= ins_pos_in;
      ins_start_ff  <= ins_start_in;
      ins_len_ff    <= ins_len_in;
      blk_start_ff  <= blk_start_in;
      blk_len_ff    <= blk_len_in;
      cmd_ff        <= cmd_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      grant_ff      <= grant_in;
      status_ff     <= status_in;
   end

endmodule

FILE: design/best_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_core
// Best-fit allocator over a byte arena with free-block coalescing.
// ----------------------------------------------------------------------------
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     req_data (bfha_pkg::req_type)
//   rsp      out        rsp_valid / rsp_ready     rsp_data (bfha_pkg::rsp_type)
//   csr      in/out     psel penable pwrite pready paddr pwdata prdata
//
// one transaction at a time, carried out by the table scans and entry shifts of
// the sequencer, one table entry per cycle
// synchronous reset empties both tables and clears the break, no clearing pass
// a result waits in the output register; the next transaction is taken then
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  bfha_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output bfha_pkg::rsp_type            rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bfha_pkg::PADDR_W-1:0] paddr,
   input  logic [bfha_pkg::PDATA_W-1:0] pwdata,
   output logic [bfha_pkg::PDATA_W-1:0] prdata,
   output logic                         pready
);
   import bfha_pkg::*;

   cfg_type cfg;
   rsp_type eng_rsp, rsp_ff, rsp_in;
   logic    eng_done, rsp_valid_ff, rsp_valid_in;

   bfha_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bfha_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req_data),
      .out_busy  (rsp_valid_ff),
      .done      (eng_done),
      .rsp       (eng_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (eng_done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: design/bfha_checker.sv
// ----------------------------------------------------------------------------
// bfha_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfha_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bfha_pkg::rsp_type rsp_data,
   input logic              pready
);
   import bfha_pkg::*;

   // busy right after a transaction is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after accept");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp dropped or changed while stalled");

   // failures never carry an address
   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.granted_address == '0)
      else $error("address on failed transaction");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_UNKNOWN)
      else $error("bad status code");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind best_fit_heap_allocator_core bfha_checker u_bfha_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .pready    (pready)
);

FILE: bench/best_fit_heap_allocator_core_test.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_core_test
// Drives allocate and free transactions under several register settings and
// random stalls, predicts every response with an internal best-fit allocator
// model and compares each response field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module best_fit_heap_allocator_core_test;
   import bfha_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic [PDATA_W-1:0] prdata;
   logic pready;

   best_fit_heap_allocator_core uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // allocator model state
   longint m_chunk, m_hdr, m_limit;
   longint f_start[FREE_SLOTS];
   longint f_len[FREE_SLOTS];
   int f_cnt;
   longint u_start[USED_SLOTS];
   longint u_len[USED_SLOTS];
   int u_cnt;
   longint m_brk;

   rsp_type expected_rsps[$];
   int errors = 0;
   int quiet = 0;
   int rsp_hold = 0;
   bit stall_on = 1'b1;
   longint live_addrs[$];

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic void f_remove(input int idx);
      for (int i = idx; i + 1 < f_cnt; i++) begin
         f_start[i] = f_start[i+1];
         f_len[i] = f_len[i+1];
      end
      f_cnt--;
   endfunction

   function automatic void f_insert(input longint s, input longint l);
      int pos;
      pos = 0;
      while (pos < f_cnt && f_start[pos] < s) pos++;
      for (int i = f_cnt; i > pos; i--) begin
         f_start[i] = f_start[i-1];
         f_len[i] = f_len[i-1];
      end
      f_start[pos] = s;
      f_len[pos] = l;
      f_cnt++;
   endfunction

   function automatic int fit_index(input longint sz);
      int b;
      b = f_cnt;
      for (int i = 0; i < f_cnt; i++) begin
         if (f_len[i] == sz) return i;
         if (f_len[i] > sz && (b == f_cnt || f_len[i] < f_len[b])) b = i;
      end
      return b;
   endfunction

   function automatic status_type model_alloc(input longint sz, output longint granted);
      longint lim, s, l;
      int b, i;
      granted = 0;
      if (sz + m_hdr > m_chunk) return ST_TOO_LARGE;
      if (sz == 0) return ST_NULL;
      if (u_cnt >= USED_SLOTS) return ST_FULL;
      b = fit_index(sz);
      if (b == f_cnt) begin
         lim = (m_limit > (64'd1 << ARENA_BITS)) ? (64'd1 << ARENA_BITS) : m_limit;
         if (m_brk + m_chunk > lim) return ST_OOM;
         for (i = 0; i < f_cnt; i++)
            if (f_start[i] + m_hdr + f_len[i] == m_brk) break;
         if (i < f_cnt) f_len[i] += m_chunk;
         else begin
            if (f_cnt >= FREE_SLOTS) return ST_FULL;
            f_insert(m_brk, m_chunk - m_hdr);
         end
         m_brk += m_chunk;
         b = fit_index(sz);
         if (b == f_cnt) return ST_OOM;
      end
      if (f_len[b] >= sz + m_hdr + 1) begin
         s = f_start[b] + f_len[b] - sz;
         l = sz;
         f_len[b] -= m_hdr + sz;
      end else begin
         s = f_start[b];
         l = f_len[b];
         f_remove(b);
      end
      u_start[u_cnt] = s;
      u_len[u_cnt] = l;
      u_cnt++;
      granted = s + m_hdr;
      return ST_OK;
   endfunction

   function automatic status_type model_free(input longint a);
      longint s, l, e;
      int u, lf, rt;
      if (a == 0) return ST_NULL;
      for (u = 0; u < u_cnt; u++)
         if (u_start[u] + m_hdr == a) break;
      if (u == u_cnt) return ST_UNKNOWN;
      s = u_start[u];
      l = u_len[u];
      e = s + m_hdr + l;
      lf = f_cnt;
      rt = f_cnt;
      for (int i = 0; i < f_cnt; i++) begin
         if (f_start[i] + m_hdr + f_len[i] == s) lf = i;
         if (f_start[i] == e) rt = i;
      end
      if (lf < f_cnt && rt < f_cnt) begin
         f_len[lf] += m_hdr + l + m_hdr + f_len[rt];
         f_remove(rt);
      end else if (lf < f_cnt) f_len[lf] += m_hdr + l;
      else if (rt < f_cnt) begin
         f_start[rt] = s;
         f_len[rt] += m_hdr + l;
      end else begin
         if (f_cnt >= FREE_SLOTS) return ST_FULL;
         f_insert(s, l);
      end
      u_cnt--;
      u_start[u] = u_start[u_cnt];
      u_len[u] = u_len[u_cnt];
      return ST_OK;
   endfunction

   function automatic rsp_type predict_rsp(input req_type r);
      rsp_type o;
      longint g;
      status_type st;
      g = 0;
      if (r.command == CMD_ALLOC) st = model_alloc(longint'(r.request_size), g);
      else st = model_free(longint'(r.user_address));
      o.granted_address = g[ADDR_W-1:0];
      o.status = st;
      if (st == ST_OK && r.command == CMD_ALLOC) live_addrs.push_back(g);
      return o;
   endfunction

   task automatic idle_burst();
      if (stall_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic send_req(input command_type c, input longint sz, input longint a);
      req_type r;
      idle_burst();
      r.command = c;
      r.request_size = sz[SIZE_W-1:0];
      r.user_address = a[ADDR_W-1:0];
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsps.push_back(predict_rsp(r));
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) report("unexpected response", rsp_data, 0);
            else begin
               rsp_type w;
               w = expected_rsps.pop_front();
               if (rsp_data.granted_address !== w.granted_address)
                  report("granted_address", rsp_data.granted_address, w.granted_address);
               if (rsp_data.status !== w.status) report("status", rsp_data.status, w.status);
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold = rsp_hold - 1;
            rsp_ready <= 1'b0;
         end else if (stall_on && $urandom_range(0, 4) == 0) begin
            rsp_hold = $urandom_range(0, 6);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 20000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input longint v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= PADDR_W'(4 * int'(idx));
      pwdata <= PDATA_W'(v);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_CHUNK_SIZE: m_chunk = v & 64'h1FFFFF;
         REG_HEADER_SIZE: m_hdr = v & 64'h7F;
         default: m_limit = v & 64'h1FFFFF;
      endcase
      @(posedge clock);
   endtask

   task automatic random_mix(input int n, input int max_sz);
      longint a;
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 50) send_req(CMD_ALLOC, $urandom_range(1, max_sz), $urandom);
         else if (k < 85 && live_addrs.size() > 0) begin
            int j;
            j = $urandom_range(0, live_addrs.size() - 1);
            a = live_addrs[j];
            live_addrs.delete(j);
            send_req(CMD_FREE, $urandom, a);
         end else if (k < 92) send_req(CMD_FREE, $urandom, $urandom_range(0, 1048575));
         else send_req(command_type'($urandom_range(0, 1)), $urandom_range(0, 1048575),
                       $urandom_range(0, 1048575));
      end
   endtask

   task automatic test_directed();
      send_req(CMD_ALLOC, 0, 0);
      send_req(CMD_ALLOC, 1048575, 1048575);
      send_req(CMD_ALLOC, 8176, 0);
      send_req(CMD_ALLOC, 8177, 0);
      send_req(CMD_FREE, 0, 0);
      send_req(CMD_FREE, 1048575, 1048575);
      send_req(CMD_ALLOC, 100, 0);
      send_req(CMD_ALLOC, 100, 0);
      send_req(CMD_ALLOC, 1, 0);
      send_req(CMD_FREE, 0, live_addrs[0]);
      send_req(CMD_FREE, 0, live_addrs[0]);
      send_req(CMD_FREE, 0, live_addrs[2]);
      send_req(CMD_FREE, 0, live_addrs[1]);
      live_addrs.delete();
      wait_drain();
   endtask

   task automatic test_tables_full();
      csr_write(REG_CHUNK_SIZE, 64);
      csr_write(REG_HEADER_SIZE, 8);
      for (int i = 0; i < 20; i++) send_req(CMD_ALLOC, 8, 0);
      wait_drain();
      for (int i = 0; i < live_addrs.size(); i += 2) send_req(CMD_FREE, 0, live_addrs[i]);
      wait_drain();
      random_mix(60, 56);
      wait_drain();
   endtask

   task automatic test_out_of_memory();
      csr_write(REG_CHUNK_SIZE, 32);
      csr_write(REG_ARENA_LIMIT, 200);
      random_mix(80, 24);
      wait_drain();
      csr_write(REG_ARENA_LIMIT, 0);
      random_mix(20, 24);
      wait_drain();
   endtask

   task automatic test_header_change();
      csr_write(REG_ARENA_LIMIT, 2097151);
      csr_write(REG_CHUNK_SIZE, 2097151);
      csr_write(REG_HEADER_SIZE, 64);
      random_mix(80, 4000);
      wait_drain();
      csr_write(REG_HEADER_SIZE, 0);
      random_mix(40, 4000);
      wait_drain();
      csr_write(REG_HEADER_SIZE, 127);
      random_mix(40, 4000);
      wait_drain();
   endtask

   task automatic test_random();
      csr_write(REG_CHUNK_SIZE, 1048576);
      csr_write(REG_HEADER_SIZE, 16);
      random_mix(200, 3000);
      wait_drain();
      csr_write(REG_CHUNK_SIZE, 512);
      stall_on = 1'b0;
      random_mix(200, 200);
      wait_drain();
   endtask

   initial begin
      m_chunk = 8192;
      m_hdr = 16;
      m_limit = 1048576;
      f_cnt = 0;
      u_cnt = 0;
      m_brk = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_tables_full();
      test_out_of_memory();
      test_header_change();
      test_random();
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: best_fit_heap_allocator_core.f
design/bfha_pkg.sv
design/bfha_csr.sv
design/bfha_engine.sv
design/best_fit_heap_allocator_core.sv
design/bfha_checker.sv
bench/best_fit_heap_allocator_core_test.sv
